[hw/rtl/kgr_pkg.sv]
// Shared types and codes of the key grab event router.
package kgr_pkg;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_GRAB   = 2'd1;
    localparam logic [1:0] OP_UNGRAB = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] MODE_EXCL   = 2'd0;
    localparam logic [1:0] MODE_OVR    = 2'd1;
    localparam logic [1:0] MODE_TOP    = 2'd2;
    localparam logic [1:0] MODE_SHARED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ALREADY = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_KEY = 2'd3;

    localparam logic CFG_FOCUS = 1'b0;
    localparam logic CFG_TOP   = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic       bad_key;
        logic [7:0] key_code;
        logic [1:0] grab_mode;
        logic [7:0] client;
    } t_cmd;

endpackage

[hw/rtl/kgr_front.sv]
// Front end: accepts input words, flags bad keys, two-entry command queue.
module kgr_front import kgr_pkg::*; #(
    parameter int NUM_KEYS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_key_code,
    input  logic [1:0] i_grab_mode,
    input  logic [7:0] i_client,
    input  logic       i_clearing,
    output logic       o_q_valid,
    output t_cmd       o_q_cmd,
    input  logic       i_q_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd;

    assign o_stall   = (r_cnt == 2'd2) || i_clearing;
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        cmd.opcode    = i_opcode;
        cmd.key_code  = i_key_code;
        cmd.grab_mode = i_grab_mode;
        cmd.client    = i_client;
        cmd.bad_key   = (i_key_code == 8'd0) || (32'(i_key_code) >= NUM_KEYS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

[hw/rtl/kgr_back.sv]
// Back end: grab list memory, command sequencer and result register.
module kgr_back import kgr_pkg::*; #(
    parameter int NUM_KEYS       = 256,
    parameter int SLOTS_PER_LIST = 8,
    parameter int CLIENT_BITS    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_clearing,
    input  logic [7:0] i_focus,
    input  logic [7:0] i_top,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_dest_client,
    output logic       o_delivered,
    output logic [1:0] o_status,
    output logic       o_key_grabbed,
    output logic       o_last
);
    localparam int KW   = $clog2(NUM_KEYS);
    localparam int AW   = KW + 2;
    localparam int ROWS = NUM_KEYS * 4;
    localparam int S    = SLOTS_PER_LIST;
    localparam int CB   = CLIENT_BITS;
    localparam int WW   = $clog2(S + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DLV  = 3'd4;
    localparam logic [2:0] S_SH   = 3'd5;

    typedef logic [CB-1:0]        t_cid;
    typedef logic [S-1:0][CB-1:0] t_row;

    function automatic t_cid to_cid(input logic [7:0] x);
        logic [CB+7:0] w;
        w = {{CB{1'b0}}, x};
        return w[CB-1:0];
    endfunction

    function automatic logic [7:0] to_byte(input t_cid c);
        logic [CB+7:0] w;
        w = {8'd0, c};
        return w[7:0];
    endfunction

    logic [S*CB-1:0] mem [ROWS];

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_m, n_m;
    t_cmd          r_cmd, n_cmd;
    t_row          r_rdata;
    logic [AW-1:0] r_clr, n_clr;
    t_cid          r_ex, n_ex, r_or, n_or;
    logic          r_tp, n_tp, r_any, n_any;
    logic [S-1:0]  r_mask, n_mask;
    t_row          r_sh, n_sh;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_dest, n_dest;
    logic          r_dlv, n_dlv, r_gr, n_gr, r_last, n_last;
    logic [1:0]    r_st, n_st;

    logic          we;
    logic [AW-1:0] raddr, waddr;
    t_row          wdata;
    logic [KW+7:0] kwide;
    t_cid          cl, focus_c, top_c, sel;
    logic [S-1:0]  nz, keep, shm, low;
    logic          has_cl, has_top, full, refused, any_now, can_emit, run;
    t_row          ins_row, cmp_row;
    logic [WW-1:0] pc [S];
    logic [1:0]    g_st;

    assign kwide      = {{KW{1'b0}}, r_cmd.key_code};
    assign raddr      = {kwide[KW-1:0], r_m};
    assign cl         = to_cid(r_cmd.client);
    assign focus_c    = to_cid(i_focus);
    assign top_c      = to_cid(i_top);
    assign can_emit   = !r_ovalid || !i_stall;
    assign o_clearing = (r_state == S_CLR);

    // list scans over one row
    always_comb begin
        has_cl  = 1'b0;
        has_top = 1'b0;
        run     = 1'b1;
        for (int i = 0; i < S; i++) begin
            nz[i]   = (r_rdata[i] != '0);
            keep[i] = nz[i] && (r_rdata[i] != cl);
            has_cl  = has_cl  || (nz[i] && r_rdata[i] == cl);
            has_top = has_top || (nz[i] && r_rdata[i] == top_c);
            run     = run && nz[i];
            shm[i]  = run && !((focus_c != '0) && (r_rdata[i] == focus_c));
        end
        full    = &nz;
        any_now = r_any || nz[0];
        refused = (r_cmd.grab_mode == MODE_EXCL) ? nz[0] : has_cl;
        ins_row[0] = cl;
        for (int i = 1; i < S; i++) begin
            ins_row[i] = r_rdata[i-1];
        end
        pc[0] = '0;
        for (int i = 1; i < S; i++) begin
            pc[i] = pc[i-1] + WW'(keep[i-1]);
        end
        cmp_row = '0;
        for (int p = 0; p < S; p++) begin
            for (int i = 0; i < S; i++) begin
                if (keep[i] && pc[i] == WW'(p)) begin
                    cmp_row[p] = r_rdata[i];
                end
            end
        end
        if (cl == '0) begin
            g_st = ST_OK;
        end else if (refused) begin
            g_st = ST_ALREADY;
        end else if (full) begin
            g_st = ST_FULL;
        end else begin
            g_st = ST_OK;
        end
    end

    // next shared client: lowest set bit of the pending mask
    always_comb begin
        low = r_mask & (~r_mask + 1'b1);
        sel = '0;
        for (int i = 0; i < S; i++) begin
            if (low[i]) begin
                sel = r_sh[i];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_m      = r_m;
        n_cmd    = r_cmd;
        n_clr    = r_clr;
        n_ex     = r_ex;
        n_or     = r_or;
        n_tp     = r_tp;
        n_any    = r_any;
        n_mask   = r_mask;
        n_sh     = r_sh;
        n_ovalid = r_ovalid && i_stall;
        n_dest   = r_dest;
        n_dlv    = r_dlv;
        n_st     = r_st;
        n_gr     = r_gr;
        n_last   = r_last;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        waddr    = raddr;
        wdata    = ins_row;

        unique case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.bad_key) begin
                        if (can_emit) begin
                            o_q_pop  = 1'b1;
                            n_ovalid = 1'b1;
                            n_dest   = 8'd0;
                            n_dlv    = 1'b0;
                            n_st     = ST_BAD_KEY;
                            n_gr     = 1'b0;
                            n_last   = 1'b1;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_cmd   = i_q_cmd;
                        n_any   = 1'b0;
                        n_m     = (i_q_cmd.opcode == OP_GRAB || i_q_cmd.opcode == OP_UNGRAB)
                                  ? i_q_cmd.grab_mode : MODE_EXCL;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                unique case (r_cmd.opcode)
                    OP_GRAB, OP_UNGRAB: begin
                        if (can_emit) begin
                            if (r_cmd.opcode == OP_GRAB) begin
                                we    = (cl != '0) && !refused && !full;
                                wdata = ins_row;
                                n_st  = g_st;
                            end else begin
                                we    = (cl != '0);
                                wdata = cmp_row;
                                n_st  = ST_OK;
                            end
                            n_ovalid = 1'b1;
                            n_dest   = 8'd0;
                            n_dlv    = 1'b0;
                            n_gr     = 1'b0;
                            n_last   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (r_m == MODE_SHARED) begin
                            if (can_emit) begin
                                n_ovalid = 1'b1;
                                n_dest   = 8'd0;
                                n_dlv    = 1'b0;
                                n_st     = ST_OK;
                                n_gr     = any_now;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_any   = any_now;
                            n_m     = r_m + 2'd1;
                            n_state = S_RD;
                        end
                    end
                    OP_KEY: begin
                        unique case (r_m)
                            MODE_EXCL:   n_ex = r_rdata[0];
                            MODE_OVR:    n_or = r_rdata[0];
                            MODE_TOP:    n_tp = nz[0] && (top_c != '0) && has_top;
                            MODE_SHARED: begin
                                n_sh   = r_rdata;
                                n_mask = shm;
                            end
                        endcase
                        if (r_m == MODE_SHARED) begin
                            n_state = S_DLV;
                        end else begin
                            n_m     = r_m + 2'd1;
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_DLV: begin
                if (can_emit) begin
                    n_dlv  = 1'b1;
                    n_st   = ST_OK;
                    n_gr   = 1'b0;
                    n_last = 1'b1;
                    priority if (r_ex != '0) begin
                        n_ovalid = 1'b1;
                        n_dest   = to_byte(r_ex);
                        n_state  = S_IDLE;
                    end else if (r_or != '0) begin
                        n_ovalid = 1'b1;
                        n_dest   = to_byte(r_or);
                        n_state  = S_IDLE;
                    end else if (r_tp) begin
                        n_ovalid = 1'b1;
                        n_dest   = to_byte(top_c);
                        n_state  = S_IDLE;
                    end else if (focus_c != '0) begin
                        n_ovalid = 1'b1;
                        n_dest   = to_byte(focus_c);
                        n_last   = (r_mask == '0);
                        n_state  = (r_mask == '0) ? S_IDLE : S_SH;
                    end else if (r_mask == '0) begin
                        n_ovalid = 1'b1;
                        n_dest   = 8'd0;
                        n_dlv    = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_state  = S_SH;
                    end
                end
            end
            S_SH: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_dest   = to_byte(sel);
                    n_dlv    = 1'b1;
                    n_st     = ST_OK;
                    n_gr     = 1'b0;
                    n_last   = ((r_mask & ~low) == '0);
                    n_mask   = r_mask & ~low;
                    if ((r_mask & ~low) == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_m    <= n_m;
        r_cmd  <= n_cmd;
        r_ex   <= n_ex;
        r_or   <= n_or;
        r_tp   <= n_tp;
        r_any  <= n_any;
        r_mask <= n_mask;
        r_sh   <= n_sh;
        r_dest <= n_dest;
        r_dlv  <= n_dlv;
        r_st   <= n_st;
        r_gr   <= n_gr;
        r_last <= n_last;
    end

    assign o_valid       = r_ovalid;
    assign o_dest_client = r_dest;
    assign o_delivered   = r_dlv;
    assign o_status      = r_st;
    assign o_key_grabbed = r_gr;
    assign o_last        = r_last;
endmodule

[hw/rtl/key_grab_event_router.sv]
// Top level of the key grab event router.
//
// Input channel (i_valid / o_stall) carries one command word: key event,
// grab, ungrab or grab query for a key code. Output channel (o_valid /
// i_stall) returns result words; o_last marks the final word of a command.
// A key event yields one word per receiving client, up to SLOTS_PER_LIST+1.
// Configuration: i_cfg_we writes focus (index 0) or top client (index 1).
//
// Flow: a two-entry queue decouples the front from the sequencer, so new
// words are taken while results wait. Bad key codes are answered from
// the idle state; grab and ungrab read and check one list row, a query
// or key event all four rows of the key, each row read in S_RD and
// checked in S_CHK, as the list memory read is registered. A key event
// then emits one word for each further shared client delivered.
//
// Reset: a clearing pass writes every list row to empty, all NUM_KEYS*4
// rows (1024 by default); o_stall is high meanwhile. A stalled receiver
// holds the result word in place; the queue fills and then stalls input.
module key_grab_event_router import kgr_pkg::*; #(
    parameter int NUM_KEYS       = 256,
    parameter int SLOTS_PER_LIST = 8,
    parameter int CLIENT_BITS    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_key_code,
    input  logic [1:0] i_grab_mode,
    input  logic [7:0] i_client,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_dest_client,
    output logic       o_delivered,
    output logic [1:0] o_status,
    output logic       o_key_grabbed,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    logic [7:0] r_focus, r_top;
    logic       q_valid, q_pop, clearing;
    t_cmd       q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus <= 8'd0;
            r_top   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOCUS: r_focus <= i_cfg_data;
                CFG_TOP:   r_top   <= i_cfg_data;
            endcase
        end
    end

    kgr_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_key_code  (i_key_code),
        .i_grab_mode (i_grab_mode),
        .i_client    (i_client),
        .i_clearing  (clearing),
        .o_q_valid   (q_valid),
        .o_q_cmd     (q_cmd),
        .i_q_pop     (q_pop)
    );

    // sequencer owns the list memory and the result register
    kgr_back #(
        .NUM_KEYS       (NUM_KEYS),
        .SLOTS_PER_LIST (SLOTS_PER_LIST),
        .CLIENT_BITS    (CLIENT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .i_focus       (r_focus),
        .i_top         (r_top),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_dest_client (o_dest_client),
        .o_delivered   (o_delivered),
        .o_status      (o_status),
        .o_key_grabbed (o_key_grabbed),
        .o_last        (o_last)
    );
endmodule

[hw/rtl/kgr_checker.sv]
// Port-level checks of the key grab event router, bound to the top level.
module kgr_checker import kgr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_dest_client,
    input logic       o_delivered,
    input logic [1:0] o_status,
    input logic       o_key_grabbed,
    input logic       o_last
);
    // clearing pass follows reset, no result left over
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("no clearing pass after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_client) && $stable(o_last))
        else $error("stalled result word changed");

    a_nodlv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_delivered |-> o_dest_client == 8'd0)
        else $error("undelivered word names a client");

    a_dlv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_delivered |-> o_status == ST_OK && !o_key_grabbed)
        else $error("delivery word with status or query flag");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK || o_key_grabbed) |-> o_last)
        else $error("single-word result not marked last");
endmodule

bind key_grab_event_router kgr_checker u_kgr_checker (.*);
